>>> rtl/glp_pkg.sv
// Shared types, constants and character helpers for the G-code line parser.
package glp_pkg;

   // Default sizes handed to the top level.
   localparam int MAX_LINE_DEF  = 256;
   localparam int CODE_BITS_DEF = 16;
   localparam int LETTERS       = 26;

   // Position counters hold up to 256; the scan pointer runs a few past the end.
   localparam int POS_W = 9;
   localparam int P_W   = 10;

   // Characters of interest.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UG    = 8'h47;
   localparam logic [7:0] CH_UM    = 8'h4D;
   localparam logic [7:0] CH_UN    = 8'h4E;
   localparam logic [7:0] CH_UT    = 8'h54;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   // Command letters as reported.
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_G    = 2'd1;
   localparam logic [1:0] CMD_M    = 2'd2;
   localparam logic [1:0] CMD_T    = 2'd3;

   // Result kinds.
   localparam logic KIND_PARAM   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [4:0] LETTER_N    = 5'd13;
   localparam logic [4:0] LAST_LETTER = 5'd25;
   localparam logic [15:0] CODE_BANG  = 16'd32;

   // Line handed from the front to the back.
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] len;
      logic             sat;
   } line_desc_type;

   // Back-to-front handshake on the line buffer.
   typedef struct packed {
      logic take;
      logic release_buf;
   } back_ctrl_type;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_LA && c <= CH_LZ) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CH_UA) && (c <= CH_UZ);
   endfunction

   // M codes that take the rest of the line as their string argument.
   function automatic logic is_string_code(input logic [15:0] code);
      return (code == 16'd16) || (code == 16'd23) || (code == 16'd28) ||
             (code == 16'd30) || (code == 16'd117) || (code == 16'd118) ||
             (code == 16'd928) || ((code >= 16'd810) && (code <= 16'd819));
   endfunction

endpackage

>>> rtl/gcode_line_parser.sv
// Top level of the G-code line parser: front end, line buffer and back end.
//
//  channel  direction  handshake            payload
//  req_     in         push / full          ch, end_of_line
//  rsp_     out        empty / pop          eleven result fields
//  csr_     in         valid / ready        wdata (subcode enable)
//
// One character is taken per cycle while the line buffer is free.
// After the end-of-line transaction the back end scans the buffer one
// character at a time through the buffer read port; full stays high meanwhile.
// The buffer is released before the drain, which steps through every letter and
// then the summary, waiting whenever rsp_ stalls; the next line may be typed in
// during the drain.
// Reset is synchronous and active high; it clears the subcode enable.
module gcode_line_parser
   import glp_pkg::*;
#(
   parameter int MAX_LINE  = MAX_LINE_DEF,
   parameter int CODE_BITS = CODE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_line,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_item_kind,
   output logic [4:0]  rsp_letter_index,
   output logic [7:0]  rsp_value_offset,
   output logic        rsp_has_value,
   output logic [1:0]  rsp_command_code,
   output logic [15:0] rsp_code_number,
   output logic [25:0] rsp_seen_letters,
   output logic [7:0]  rsp_string_offset,
   output logic        rsp_has_string,
   output logic        rsp_overflow,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata
);

   line_desc_type  desc;
   back_ctrl_type  ctrl;
   logic [P_W-1:0] rd_addr;
   logic [7:0]     rd_data;

   // Character intake and line buffer.
   glp_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_ch          (req_ch),
      .req_end_of_line (req_end_of_line),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .desc            (desc),
      .ctrl            (ctrl)
   );

   // Line scan and result drain.
   glp_back #(
      .MAX_LINE  (MAX_LINE),
      .CODE_BITS (CODE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .desc              (desc),
      .ctrl              (ctrl),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_letter_index  (rsp_letter_index),
      .rsp_value_offset  (rsp_value_offset),
      .rsp_has_value     (rsp_has_value),
      .rsp_command_code  (rsp_command_code),
      .rsp_code_number   (rsp_code_number),
      .rsp_seen_letters  (rsp_seen_letters),
      .rsp_string_offset (rsp_string_offset),
      .rsp_has_string    (rsp_has_string),
      .rsp_overflow      (rsp_overflow),
      .rsp_last          (rsp_last)
   );

endmodule

>>> rtl/glp_front.sv
// Front end: takes characters into the line buffer and finds the effective line length.
module glp_front
   import glp_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_ch,
   input  logic              req_end_of_line,
   input  logic [P_W-1:0]    rd_addr,
   output logic [7:0]        rd_data,
   output line_desc_type     desc,
   input  back_ctrl_type     ctrl
);

   localparam int IW = $clog2(MAX_LINE);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

   logic [7:0]       mem [MAX_LINE];
   logic [7:0]       rd_data_ff;
   logic             busy_ff, busy_in;
   line_desc_type    desc_ff, desc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] cut_len_ff, cut_len_in;
   logic [POS_W-1:0] lastns_ff, lastns_in;
   logic             cut_ff, cut_in;
   logic             sat_ff, sat_in;
   logic             accept;
   logic             stored;

   assign accept   = req_push && !busy_ff;
   assign stored   = pos_ff < POS_MAX;
   assign req_full = busy_ff;
   assign desc     = desc_ff;
   assign rd_data  = rd_data_ff;

   // Line buffer: written by incoming transactions, read by the back end.
   always_ff @(posedge clock) begin
      if (accept && stored) begin
         mem[pos_ff[IW-1:0]] <= req_ch;
      end
      rd_data_ff <= mem[rd_addr[IW-1:0]];
   end

   // Track the first NUL or checksum star, trimming spaces before the star.
   always_comb begin
      busy_in    = busy_ff;
      desc_in    = desc_ff;
      pos_in     = pos_ff;
      cut_len_in = cut_len_ff;
      lastns_in  = lastns_ff;
      cut_in     = cut_ff;
      sat_in     = sat_ff;
      if (ctrl.take) begin
         desc_in.valid = 1'b0;
      end
      if (ctrl.release_buf) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         if (stored) begin
            pos_in = pos_ff + POS_W'(1);
            if (!cut_ff) begin
               if (req_ch == CH_NUL) begin
                  cut_in     = 1'b1;
                  cut_len_in = pos_ff;
               end else if (req_ch == CH_STAR) begin
                  cut_in     = 1'b1;
                  cut_len_in = lastns_ff;
               end else if (req_ch != CH_SPACE) begin
                  lastns_in = pos_ff + POS_W'(1);
               end
            end
         end else begin
            sat_in = 1'b1;
         end
         if (req_end_of_line) begin
            desc_in.valid = 1'b1;
            desc_in.len   = cut_in ? cut_len_in : pos_in;
            desc_in.sat   = sat_in;
            busy_in       = 1'b1;
            pos_in        = '0;
            cut_in        = 1'b0;
            lastns_in     = '0;
            sat_in        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         desc_ff.valid <= 1'b0;
         pos_ff        <= '0;
         cut_ff        <= 1'b0;
         lastns_ff     <= '0;
         sat_ff        <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         desc_ff.valid <= desc_in.valid;
         pos_ff        <= pos_in;
         cut_ff        <= cut_in;
         lastns_ff     <= lastns_in;
         sat_ff        <= sat_in;
      end
      desc_ff.len <= desc_in.len;
      desc_ff.sat <= desc_in.sat;
      cut_len_ff  <= cut_len_in;
   end

   // The buffer is only freed by the back end.
   a_busy_release: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(ctrl.release_buf))
      else $error("line buffer freed without a release");

endmodule

>>> rtl/glp_back.sv
// Back end: scans the buffered line, records parameters and drains the results.
module glp_back
   import glp_pkg::*;
#(
   parameter int MAX_LINE  = MAX_LINE_DEF,
   parameter int CODE_BITS = CODE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata,
   input  line_desc_type     desc,
   output back_ctrl_type     ctrl,
   output logic [P_W-1:0]    rd_addr,
   input  logic [7:0]        rd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_item_kind,
   output logic [4:0]        rsp_letter_index,
   output logic [7:0]        rsp_value_offset,
   output logic              rsp_has_value,
   output logic [1:0]        rsp_command_code,
   output logic [15:0]       rsp_code_number,
   output logic [25:0]       rsp_seen_letters,
   output logic [7:0]        rsp_string_offset,
   output logic              rsp_has_string,
   output logic              rsp_overflow,
   output logic              rsp_last
);

   localparam int NB = (CODE_BITS > 16) ? 16 : CODE_BITS;
   localparam logic [NB+3:0]  CAP     = (NB+4)'((1 << NB) - 1);
   localparam logic [P_W-1:0] OFF_MAX = P_W'(MAX_LINE - 1);

   typedef enum logic [20:0] {
      ST_IDLE   = 21'h000001,
      ST_INIT   = 21'h000002,
      ST_LEAD   = 21'h000004,
      ST_NCHK   = 21'h000008,
      ST_NSKIP  = 21'h000010,
      ST_NDIG   = 21'h000020,
      ST_NSP    = 21'h000040,
      ST_CMD    = 21'h000080,
      ST_CSP    = 21'h000100,
      ST_NUM    = 21'h000200,
      ST_SUB    = 21'h000400,
      ST_SUBD   = 21'h000800,
      ST_PSP    = 21'h001000,
      ST_STRCHK = 21'h002000,
      ST_LOOP   = 21'h004000,
      ST_LSP    = 21'h008000,
      ST_TAIL   = 21'h010000,
      ST_TNUM   = 21'h020000,
      ST_TSP    = 21'h040000,
      ST_DRAIN  = 21'h080000,
      ST_SUM    = 21'h100000
   } state_type;

   state_type        state_ff, state_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [7:0]       w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic             pend_ff, pend_in;
   logic             inr_ff;
   logic [1:0]       fill_ff, fill_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic             sub_en_ff;
   logic [1:0]       letter_ff, letter_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [NB-1:0]    num_ff, num_in;
   logic             sat_ff, sat_in;
   logic [25:0]      seen_ff, seen_in;
   logic [7:0]       voff_ff [LETTERS];
   logic             vhas_ff [LETTERS];
   logic [7:0]       sstart_ff, sstart_in;
   logic             sfound_ff, sfound_in;
   logic [4:0]       lt_ff, lt_in;
   logic [4:0]       i_ff, i_in;

   // Result register.
   logic             ovalid_ff, ovalid_in;
   logic             okind_ff, okind_in;
   logic [4:0]       olet_ff, olet_in;
   logic [7:0]       ooff_ff, ooff_in;
   logic             ohas_ff, ohas_in;
   logic [1:0]       ocmd_ff, ocmd_in;
   logic [15:0]      ocode_ff, ocode_in;
   logic [25:0]      oseen_ff, oseen_in;
   logic [7:0]       ostr_ff, ostr_in;
   logic             ohstr_ff, ohstr_in;
   logic             oovf_ff, oovf_in;
   logic             olast_ff, olast_in;

   logic             do_shift, rec_en, rec_has, str_en, goto_done, emit, can_emit;
   logic [4:0]       rec_idx;
   logic [P_W-1:0]   rec_off, str_off;
   logic [7:0]       c0u;
   logic [NB+3:0]    num_next;
   logic             has_num;

   function automatic logic [7:0] clamp_off(input logic [P_W-1:0] off);
      return (off > OFF_MAX) ? OFF_MAX[7:0] : off[7:0];
   endfunction

   assign csr_ready = 1'b1;
   assign rd_addr   = p_ff + P_W'(3);
   assign can_emit  = !ovalid_ff || rsp_pop;
   assign c0u       = upcase(w0_ff);
   assign num_next  = {num_ff, 3'b000} + {2'b00, num_ff, 1'b0} +
                      (NB+4)'(w0_ff - CH_ZERO);
   assign has_num   = is_digit(w0_ff) || (w0_ff == CH_DOT && is_digit(w1_ff)) ||
                      (is_sign(w0_ff) && (is_digit(w1_ff) ||
                       (w1_ff == CH_DOT && is_digit(w2_ff))));

   // Scan sequencer over a three-character window of the line.
   always_comb begin
      state_in  = state_ff;
      p_in      = p_ff;
      w0_in     = w0_ff;
      w1_in     = w1_ff;
      w2_in     = w2_ff;
      pend_in   = pend_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      letter_in = letter_ff;
      cmd_in    = cmd_ff;
      num_in    = num_ff;
      sat_in    = sat_ff;
      sstart_in = sstart_ff;
      sfound_in = sfound_ff;
      lt_in     = lt_ff;
      i_in      = i_ff;
      do_shift  = 1'b0;
      rec_en    = 1'b0;
      rec_idx   = lt_ff;
      rec_off   = p_ff;
      rec_has   = 1'b0;
      str_en    = 1'b0;
      str_off   = p_ff;
      goto_done = 1'b0;
      emit      = 1'b0;
      ctrl.take = 1'b0;
      okind_in  = okind_ff;
      olet_in   = olet_ff;
      ooff_in   = ooff_ff;
      ohas_in   = ohas_ff;
      ocmd_in   = ocmd_ff;
      ocode_in  = ocode_ff;
      oseen_in  = oseen_ff;
      ostr_in   = ostr_ff;
      ohstr_in  = ohstr_ff;
      oovf_in   = oovf_ff;
      olast_in  = olast_ff;

      case (state_ff)
         ST_IDLE: begin
            if (desc.valid) begin
               ctrl.take = 1'b1;
               len_in    = desc.len;
               sat_in    = desc.sat;
               cmd_in    = CMD_NONE;
               num_in    = '0;
               sstart_in = '0;
               sfound_in = 1'b0;
               p_in      = {P_W{1'b1}} - P_W'(2);
               fill_in   = '0;
               state_in  = ST_INIT;
            end
         end
         ST_INIT: begin
            if (!pend_ff) begin
               if (fill_ff == 2'd3) begin
                  state_in = ST_LEAD;
               end else begin
                  do_shift = 1'b1;
                  fill_in  = fill_ff + 2'd1;
               end
            end
         end
         ST_LEAD: begin
            if (!pend_ff) begin
               if (w0_ff == CH_SPACE) do_shift = 1'b1;
               else state_in = ST_NCHK;
            end
         end
         ST_NCHK: begin
            if (!pend_ff) begin
               if (c0u == CH_UN && (is_digit(w1_ff) || is_sign(w1_ff))) begin
                  rec_en   = 1'b1;
                  rec_idx  = LETTER_N;
                  rec_off  = p_ff + P_W'(1);
                  rec_has  = 1'b1;
                  do_shift = 1'b1;
                  state_in = ST_NSKIP;
               end else begin
                  state_in = ST_CMD;
               end
            end
         end
         ST_NSKIP: begin
            if (!pend_ff) begin
               do_shift = 1'b1;
               state_in = ST_NDIG;
            end
         end
         ST_NDIG: begin
            if (!pend_ff) begin
               if (is_digit(w0_ff)) do_shift = 1'b1;
               else state_in = ST_NSP;
            end
         end
         ST_NSP: begin
            if (!pend_ff) begin
               if (w0_ff == CH_SPACE) do_shift = 1'b1;
               else state_in = ST_CMD;
            end
         end
         ST_CMD: begin
            if (!pend_ff) begin
               if (c0u == CH_UG || c0u == CH_UM || c0u == CH_UT) begin
                  letter_in = (c0u == CH_UG) ? CMD_G : ((c0u == CH_UM) ? CMD_M : CMD_T);
                  do_shift  = 1'b1;
                  state_in  = ST_CSP;
               end else begin
                  goto_done = 1'b1;
               end
            end
         end
         ST_CSP: begin
            if (!pend_ff) begin
               if (w0_ff == CH_SPACE) begin
                  do_shift = 1'b1;
               end else if (is_digit(w0_ff)) begin
                  num_in   = '0;
                  state_in = ST_NUM;
               end else begin
                  goto_done = 1'b1;
               end
            end
         end
         ST_NUM: begin
            // One decimal digit a step, saturating at the cap.
            if (!pend_ff) begin
               if (is_digit(w0_ff)) begin
                  if (num_next > CAP) begin
                     num_in = CAP[NB-1:0];
                     sat_in = 1'b1;
                  end else begin
                     num_in = num_next[NB-1:0];
                  end
                  do_shift = 1'b1;
               end else begin
                  cmd_in   = letter_ff;
                  state_in = ST_SUB;
               end
            end
         end
         ST_SUB: begin
            if (!pend_ff) begin
               if (sub_en_ff && w0_ff == CH_DOT) begin
                  do_shift = 1'b1;
                  state_in = ST_SUBD;
               end else begin
                  state_in = ST_PSP;
               end
            end
         end
         ST_SUBD: begin
            if (!pend_ff) begin
               if (is_digit(w0_ff)) do_shift = 1'b1;
               else state_in = ST_PSP;
            end
         end
         ST_PSP: begin
            if (!pend_ff) begin
               if (w0_ff == CH_SPACE) do_shift = 1'b1;
               else state_in = ST_STRCHK;
            end
         end
         ST_STRCHK: begin
            if (cmd_ff == CMD_M && is_string_code(16'(num_ff))) begin
               str_en    = 1'b1;
               goto_done = 1'b1;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (!pend_ff) begin
               if (c0u == CH_NUL) begin
                  goto_done = 1'b1;
               end else if (c0u == CH_BANG && cmd_ff == CMD_M &&
                            16'(num_ff) == CODE_BANG) begin
                  str_en    = 1'b1;
                  str_off   = p_ff + P_W'(1);
                  goto_done = 1'b1;
               end else if (is_upper(c0u)) begin
                  lt_in    = 5'(c0u - CH_UA);
                  do_shift = 1'b1;
                  state_in = ST_LSP;
               end else begin
                  str_en   = !sfound_ff;
                  do_shift = 1'b1;
                  state_in = ST_TAIL;
               end
            end
         end
         ST_LSP: begin
            if (!pend_ff) begin
               if (w0_ff == CH_SPACE) begin
                  do_shift = 1'b1;
               end else begin
                  str_en   = !has_num && !sfound_ff;
                  str_off  = p_ff - P_W'(1);
                  rec_en   = 1'b1;
                  rec_has  = has_num;
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (!pend_ff) begin
               state_in = is_upper(w0_ff) ? ST_LOOP : ST_TNUM;
            end
         end
         ST_TNUM: begin
            if (!pend_ff) begin
               if (is_digit(w0_ff) || w0_ff == CH_DOT || is_sign(w0_ff)) do_shift = 1'b1;
               else state_in = ST_TSP;
            end
         end
         ST_TSP: begin
            if (!pend_ff) begin
               if (w0_ff == CH_SPACE) do_shift = 1'b1;
               else state_in = ST_LOOP;
            end
         end
         ST_DRAIN: begin
            // One letter a cycle; seen letters wait for a free result register.
            if (!seen_ff[i_ff] || can_emit) begin
               if (seen_ff[i_ff]) begin
                  emit     = 1'b1;
                  okind_in = KIND_PARAM;
                  olet_in  = i_ff;
                  ooff_in  = voff_ff[i_ff];
                  ohas_in  = vhas_ff[i_ff];
                  ocmd_in  = CMD_NONE;
                  ocode_in = '0;
                  oseen_in = '0;
                  ostr_in  = '0;
                  ohstr_in = 1'b0;
                  oovf_in  = 1'b0;
                  olast_in = 1'b0;
               end
               if (i_ff == LAST_LETTER) state_in = ST_SUM;
               else i_in = i_ff + 5'd1;
            end
         end
         ST_SUM: begin
            if (can_emit) begin
               emit     = 1'b1;
               okind_in = KIND_SUMMARY;
               olet_in  = '0;
               ooff_in  = '0;
               ohas_in  = 1'b0;
               ocmd_in  = cmd_ff;
               ocode_in = 16'(num_ff);
               oseen_in = seen_ff;
               ostr_in  = sfound_ff ? sstart_ff : 8'd0;
               ohstr_in = sfound_ff;
               oovf_in  = sat_ff;
               olast_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Window shift and refill from the buffer read port.
      if (do_shift) begin
         p_in    = p_ff + P_W'(1);
         w0_in   = w1_ff;
         w1_in   = w2_ff;
         pend_in = 1'b1;
      end
      if (pend_ff) begin
         w2_in   = inr_ff ? rd_data : CH_NUL;
         pend_in = 1'b0;
      end

      if (str_en) begin
         sfound_in = 1'b1;
         sstart_in = clamp_off(str_off);
      end
      if (goto_done) begin
         state_in = ST_DRAIN;
         i_in     = '0;
      end
      ctrl.release_buf = goto_done;
   end

   always_comb begin
      seen_in = seen_ff;
      if (ctrl.take) seen_in = '0;
      if (rec_en) seen_in[rec_idx] = 1'b1;
      ovalid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : ovalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= 1'b0;
         sub_en_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         seen_ff   <= '0;
         sfound_ff <= 1'b0;
         cmd_ff    <= CMD_NONE;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
         seen_ff   <= seen_in;
         sfound_ff <= sfound_in;
         cmd_ff    <= cmd_in;
         if (csr_valid && csr_ready) sub_en_ff <= csr_wdata;
      end
      inr_ff    <= rd_addr < P_W'(len_ff);
      p_ff      <= p_in;
      w0_ff     <= w0_in;
      w1_ff     <= w1_in;
      w2_ff     <= w2_in;
      fill_ff   <= fill_in;
      len_ff    <= len_in;
      letter_ff <= letter_in;
      num_ff    <= num_in;
      sat_ff    <= sat_in;
      sstart_ff <= sstart_in;
      lt_ff     <= lt_in;
      i_ff      <= i_in;
      okind_ff  <= okind_in;
      olet_ff   <= olet_in;
      ooff_ff   <= ooff_in;
      ohas_ff   <= ohas_in;
      ocmd_ff   <= ocmd_in;
      ocode_ff  <= ocode_in;
      oseen_ff  <= oseen_in;
      ostr_ff   <= ostr_in;
      ohstr_ff  <= ohstr_in;
      oovf_ff   <= oovf_in;
      olast_ff  <= olast_in;
      if (rec_en) begin
         voff_ff[rec_idx] <= rec_has ? clamp_off(rec_off) : 8'd0;
         vhas_ff[rec_idx] <= rec_has;
      end
   end

   assign rsp_empty         = !ovalid_ff;
   assign rsp_item_kind     = okind_ff;
   assign rsp_letter_index  = olet_ff;
   assign rsp_value_offset  = ooff_ff;
   assign rsp_has_value     = ohas_ff;
   assign rsp_command_code  = ocmd_ff;
   assign rsp_code_number   = ocode_ff;
   assign rsp_seen_letters  = oseen_ff;
   assign rsp_string_offset = ostr_ff;
   assign rsp_has_string    = ohstr_ff;
   assign rsp_overflow      = oovf_ff;
   assign rsp_last          = olast_ff;

   // No buffer read is outstanding once the scan has finished.
   a_no_read_after_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !(state_ff == ST_IDLE || state_ff == ST_DRAIN || state_ff == ST_SUM))
      else $error("buffer read outstanding outside the scan");

   // The summary closes the line.
   a_summary_ends_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && emit) |=> (state_ff == ST_IDLE))
      else $error("summary did not return the back end to idle");

   // Only the summary carries the last flag.
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff |-> (olast_ff == okind_ff))
      else $error("last flag and result kind disagree");

endmodule
